### hdl/cec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cec_pkg
// shared widths, pipeline word types and saturation helper for the
// circle event circumcircle core
// ----------------------------------------------------------------------------
package cec_pkg;

    localparam int C_COORD_W  = 16;                 // site coordinate, signed
    localparam int C_OUT_W    = 24;                 // result coordinate, signed
    localparam int C_MARGIN_W = 8;                  // det margin register

    localparam int C_DIFF_W   = C_COORD_W + 1;      // centre-relative coordinate
    localparam int C_PROD_W   = 2 * C_DIFF_W;       // product of two differences
    localparam int C_DET_W    = C_PROD_W + 2;       // doubled determinant
    localparam int C_H_W      = C_PROD_W + 1;       // squared length
    localparam int C_NUM_W    = C_DIFF_W + C_H_W + 1;   // numerator
    localparam int C_N_W      = C_NUM_W + 1;        // dividend 2|num|+|d|
    localparam int C_D_W      = C_DET_W + 1;        // divisor 2|d|
    localparam int C_Q_W      = 33;                 // quotient bits before clamp
    localparam int C_OFS_W    = 32;                 // clamped offset magnitude
    localparam int C_SQ_W     = 2 * C_OFS_W;        // sum of squares
    localparam int C_SREM_W   = C_OFS_W + 4;        // root remainder
    localparam int C_SUM_W    = C_OFS_W + 4;        // final sums before clamp

    localparam logic [C_OFS_W-1:0] C_OFS_LIMIT = 32'h8100_0000;

    typedef struct packed {
        logic                        valid;
        logic                        event_ok;
        logic signed [C_COORD_W-1:0] bx;
        logic signed [C_COORD_W-1:0] by;
    } t_side;

    typedef struct packed {
        t_side              side;
        logic [C_N_W-1:0]   nx;
        logic [C_N_W-1:0]   ny;
        logic [C_D_W-1:0]   den;
        logic               neg_x;
        logic               neg_y;
    } t_div_in;

    typedef struct packed {
        t_side                     side;
        logic signed [C_OFS_W:0]   x;
        logic signed [C_OFS_W:0]   y;
    } t_ofs;

    typedef struct packed {
        t_side                     side;
        logic signed [C_OFS_W:0]   x;
        logic signed [C_OFS_W:0]   y;
        logic [C_OFS_W-1:0]        root;
    } t_res;

    // clamp to the output range, msb of the result flags a clamp
    function automatic logic [C_OUT_W:0] sat_out(input logic signed [C_SUM_W-1:0] v);
        logic signed [C_SUM_W-1:0] hi;
        logic signed [C_SUM_W-1:0] lo;
        logic [C_OUT_W:0]          res;
        hi = C_SUM_W'((64'sd1 <<< (C_OUT_W - 1)) - 64'sd1);
        lo = -C_SUM_W'(64'sd1 <<< (C_OUT_W - 1));
        if (v > hi) begin
            res = {1'b1, hi[C_OUT_W-1:0]};
        end else if (v < lo) begin
            res = {1'b1, lo[C_OUT_W-1:0]};
        end else begin
            res = {1'b0, v[C_OUT_W-1:0]};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### hdl/circle_event_circumcircle_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circle_event_circumcircle_core
// circle event test and circumcircle of one beach-section triplet
// ----------------------------------------------------------------------------
// a word passes the front end, the divider, the square root and the result register in turn
// throughput: one word per cycle, set by the one-bit-per-stage divider and
//   square root pipelines
// the whole pipeline advances together; it holds only while a result waits
// reset: synchronous active low, clears every stage valid and det_margin
// ----------------------------------------------------------------------------
module circle_event_circumcircle_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration
    input  wire logic                                 i_cfg_we,
    input  wire logic [cec_pkg::C_MARGIN_W-1:0]       i_cfg_wdata,
    // input words
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic                                 i_neighbours_ok,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_left_x,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_left_y,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_centre_x,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_centre_y,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_right_x,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_right_y,
    // result words
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic                                      o_event_valid,
    output logic signed [cec_pkg::C_OUT_W-1:0]        o_vertex_x,
    output logic signed [cec_pkg::C_OUT_W-1:0]        o_vertex_y,
    output logic signed [cec_pkg::C_OUT_W-1:0]        o_event_y,
    output logic                                      o_overflow
);
    import cec_pkg::*;

    logic [C_MARGIN_W-1:0] r_det_margin;
    logic                  en;
    t_div_in               div_in;
    t_ofs                  ofs;
    t_res                  res;

    // result register
    logic                      r_valid;
    logic                      r_event;
    logic signed [C_OUT_W-1:0] r_vx, r_vy, r_ey;
    logic                      r_ovf;

    // final sums, wide enough that nothing wraps before the clamp
    logic signed [C_SUM_W-1:0] sum_vx, sum_vy, sum_ey;
    logic [C_OUT_W:0]          sat_vx, sat_vy, sat_ey;

    // every stage moves unless a finished word is held at the output
    assign en      = !(r_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_margin <= '0;
        end else if (i_cfg_we) begin
            r_det_margin <= i_cfg_wdata;
        end
    end

    // relative coordinates, determinant, event test, numerators
    cec_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_valid),
        .i_neighbours_ok (i_neighbours_ok),
        .i_left_x        (i_left_x),
        .i_left_y        (i_left_y),
        .i_centre_x      (i_centre_x),
        .i_centre_y      (i_centre_y),
        .i_right_x       (i_right_x),
        .i_right_y       (i_right_y),
        .i_margin        (r_det_margin),
        .o_div           (div_in)
    );

    // rounded centre offsets
    cec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_div   (div_in),
        .o_ofs   (ofs)
    );

    // radius
    cec_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ofs   (ofs),
        .o_res   (res)
    );

    // back to absolute coordinates, then clamp to the output range
    always_comb begin
        sum_vx = C_SUM_W'(res.x) + C_SUM_W'(res.side.bx);
        sum_vy = C_SUM_W'(res.y) + C_SUM_W'(res.side.by);
        sum_ey = sum_vy + $signed(C_SUM_W'(res.root));
        sat_vx = sat_out(sum_vx);
        sat_vy = sat_out(sum_vy);
        sat_ey = sat_out(sum_ey);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= res.side.valid;
        end
    end

    // no event gives an all-zero word
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_event <= res.side.event_ok;
            if (res.side.event_ok) begin
                r_vx  <= sat_vx[C_OUT_W-1:0];
                r_vy  <= sat_vy[C_OUT_W-1:0];
                r_ey  <= sat_ey[C_OUT_W-1:0];
                r_ovf <= sat_vx[C_OUT_W] | sat_vy[C_OUT_W] | sat_ey[C_OUT_W];
            end else begin
                r_vx  <= '0;
                r_vy  <= '0;
                r_ey  <= '0;
                r_ovf <= 1'b0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_event_valid = r_event;
    assign o_vertex_x    = r_vx;
    assign o_vertex_y    = r_vy;
    assign o_event_y     = r_ey;
    assign o_overflow    = r_ovf;

endmodule
`default_nettype wire

### hdl/cec_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cec_front
// five stage front end: relative coordinates, determinant, event test,
// circumcircle numerators and divider operands
// ----------------------------------------------------------------------------
module cec_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_en,
    input  wire logic                                 i_valid,
    input  wire logic                                 i_neighbours_ok,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_left_x,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_left_y,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_centre_x,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_centre_y,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_right_x,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_right_y,
    input  wire logic [cec_pkg::C_MARGIN_W-1:0]       i_margin,
    output cec_pkg::t_div_in                          o_div
);
    import cec_pkg::*;

    // stage 1
    t_side                      r1_side;
    logic signed [C_DIFF_W-1:0] r1_ax, r1_ay, r1_cx, r1_cy;
    // stage 2
    t_side                      r2_side;
    logic signed [C_DIFF_W-1:0] r2_ax, r2_ay, r2_cx, r2_cy;
    logic signed [C_PROD_W-1:0] r2_axcy, r2_aycx, r2_axax, r2_ayay, r2_cxcx, r2_cycy;
    // stage 3
    t_side                      r3_side;
    logic signed [C_DIFF_W-1:0] r3_ax, r3_ay, r3_cx, r3_cy;
    logic signed [C_DET_W-1:0]  r3_d;
    logic signed [C_H_W-1:0]    r3_ha, r3_hc;
    // stage 4
    t_side                      r4_side;
    logic signed [C_DET_W-1:0]  r4_d;
    logic signed [C_NUM_W-1:0]  r4_cyha, r4_ayhc, r4_axhc, r4_cxha;
    // stage 5
    t_div_in                    r5_div;

    logic signed [C_DET_W-1:0]  n3_d;
    logic signed [C_DET_W-1:0]  margin_s;
    logic signed [C_NUM_W-1:0]  n5_numx, n5_numy;
    logic [C_NUM_W-1:0]         n5_ux, n5_uy;
    logic [C_DET_W-1:0]         n5_ud;

    always_comb begin
        n3_d     = (r2_axcy - r2_aycx) <<< 1;
        margin_s = $signed(C_DET_W'(i_margin));
    end

    always_comb begin
        n5_numx = r4_cyha - r4_ayhc;
        n5_numy = r4_axhc - r4_cxha;
        n5_ux   = n5_numx[C_NUM_W-1] ? C_NUM_W'(-n5_numx) : C_NUM_W'(n5_numx);
        n5_uy   = n5_numy[C_NUM_W-1] ? C_NUM_W'(-n5_numy) : C_NUM_W'(n5_numy);
        n5_ud   = r4_d[C_DET_W-1] ? C_DET_W'(-r4_d) : C_DET_W'(r4_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side.valid      <= 1'b0;
            r2_side.valid      <= 1'b0;
            r3_side.valid      <= 1'b0;
            r4_side.valid      <= 1'b0;
            r5_div.side.valid  <= 1'b0;
        end else if (i_en) begin
            r1_side.valid      <= i_valid;
            r2_side.valid      <= r1_side.valid;
            r3_side.valid      <= r2_side.valid;
            r4_side.valid      <= r3_side.valid;
            r5_div.side.valid  <= r4_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // origin moved to the centre site
            r1_side.event_ok <= i_neighbours_ok;
            r1_side.bx       <= i_centre_x;
            r1_side.by       <= i_centre_y;
            r1_ax            <= C_DIFF_W'(i_left_x)  - C_DIFF_W'(i_centre_x);
            r1_ay            <= C_DIFF_W'(i_left_y)  - C_DIFF_W'(i_centre_y);
            r1_cx            <= C_DIFF_W'(i_right_x) - C_DIFF_W'(i_centre_x);
            r1_cy            <= C_DIFF_W'(i_right_y) - C_DIFF_W'(i_centre_y);

            r2_side.event_ok <= r1_side.event_ok;
            r2_side.bx       <= r1_side.bx;
            r2_side.by       <= r1_side.by;
            r2_ax            <= r1_ax;
            r2_ay            <= r1_ay;
            r2_cx            <= r1_cx;
            r2_cy            <= r1_cy;
            r2_axcy          <= r1_ax * r1_cy;
            r2_aycx          <= r1_ay * r1_cx;
            r2_axax          <= r1_ax * r1_ax;
            r2_ayay          <= r1_ay * r1_ay;
            r2_cxcx          <= r1_cx * r1_cx;
            r2_cycy          <= r1_cy * r1_cy;

            // counter-clockwise by more than the margin
            r3_side.event_ok <= r2_side.event_ok && (n3_d < -margin_s);
            r3_side.bx       <= r2_side.bx;
            r3_side.by       <= r2_side.by;
            r3_ax            <= r2_ax;
            r3_ay            <= r2_ay;
            r3_cx            <= r2_cx;
            r3_cy            <= r2_cy;
            r3_d             <= n3_d;
            r3_ha            <= C_H_W'(r2_axax) + C_H_W'(r2_ayay);
            r3_hc            <= C_H_W'(r2_cxcx) + C_H_W'(r2_cycy);

            r4_side.event_ok <= r3_side.event_ok;
            r4_side.bx       <= r3_side.bx;
            r4_side.by       <= r3_side.by;
            r4_d             <= r3_d;
            r4_cyha          <= r3_cy * r3_ha;
            r4_ayhc          <= r3_ay * r3_hc;
            r4_axhc          <= r3_ax * r3_hc;
            r4_cxha          <= r3_cx * r3_ha;

            // round to nearest: floor((2|n| + |d|) / (2|d|))
            r5_div.side.event_ok <= r4_side.event_ok;
            r5_div.side.bx       <= r4_side.bx;
            r5_div.side.by       <= r4_side.by;
            r5_div.nx            <= {n5_ux, 1'b0} + C_N_W'(n5_ud);
            r5_div.ny            <= {n5_uy, 1'b0} + C_N_W'(n5_ud);
            r5_div.den           <= {n5_ud, 1'b0};
            r5_div.neg_x         <= n5_numx[C_NUM_W-1] ^ r4_d[C_DET_W-1];
            r5_div.neg_y         <= n5_numy[C_NUM_W-1] ^ r4_d[C_DET_W-1];
        end
    end

    assign o_div = r5_div;

endmodule
`default_nettype wire

### hdl/cec_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cec_div
// two lane restoring divider, one quotient bit per stage, with clamp of
// the offset magnitude and sign restore
// ----------------------------------------------------------------------------
module cec_div (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire cec_pkg::t_div_in i_div,
    output cec_pkg::t_ofs   o_ofs
);
    import cec_pkg::*;

    typedef struct packed {
        t_div_in          op;
        logic             ovf_x;
        logic             ovf_y;
        logic [C_D_W-1:0] rem_x;
        logic [C_D_W-1:0] rem_y;
        logic [C_Q_W-1:0] q_x;
        logic [C_Q_W-1:0] q_y;
    } t_dst;

    t_dst r_st [0:C_Q_W];
    t_dst n_st0;
    t_ofs r_out;
    t_ofs n_out;

    // quotient wider than C_Q_W bits is beyond the clamp anyway
    always_comb begin
        n_st0       = '0;
        n_st0.op    = i_div;
        n_st0.ovf_x = C_D_W'(i_div.nx >> C_Q_W) >= i_div.den;
        n_st0.ovf_y = C_D_W'(i_div.ny >> C_Q_W) >= i_div.den;
        n_st0.rem_x = C_D_W'(i_div.nx >> C_Q_W);
        n_st0.rem_y = C_D_W'(i_div.ny >> C_Q_W);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0].op.side.valid <= 1'b0;
        end else if (i_en) begin
            r_st[0] <= n_st0;
        end
    end

    for (genvar k = 1; k <= C_Q_W; k++) begin : g_bit
        localparam int B = C_Q_W - k;
        t_dst           n_st;
        logic [C_D_W:0] tx, ty;

        always_comb begin
            n_st = r_st[k-1];
            tx   = {r_st[k-1].rem_x, r_st[k-1].op.nx[B]};
            ty   = {r_st[k-1].rem_y, r_st[k-1].op.ny[B]};
            if (tx >= {1'b0, r_st[k-1].op.den}) begin
                tx          = tx - {1'b0, r_st[k-1].op.den};
                n_st.q_x[B] = 1'b1;
            end
            if (ty >= {1'b0, r_st[k-1].op.den}) begin
                ty          = ty - {1'b0, r_st[k-1].op.den};
                n_st.q_y[B] = 1'b1;
            end
            n_st.rem_x = tx[C_D_W-1:0];
            n_st.rem_y = ty[C_D_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k].op.side.valid <= 1'b0;
            end else if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    logic [C_OFS_W-1:0] mag_x, mag_y;

    always_comb begin
        if (r_st[C_Q_W].ovf_x || r_st[C_Q_W].q_x > C_Q_W'(C_OFS_LIMIT)) begin
            mag_x = C_OFS_LIMIT;
        end else begin
            mag_x = r_st[C_Q_W].q_x[C_OFS_W-1:0];
        end
        if (r_st[C_Q_W].ovf_y || r_st[C_Q_W].q_y > C_Q_W'(C_OFS_LIMIT)) begin
            mag_y = C_OFS_LIMIT;
        end else begin
            mag_y = r_st[C_Q_W].q_y[C_OFS_W-1:0];
        end
        n_out.side = r_st[C_Q_W].op.side;
        n_out.x    = r_st[C_Q_W].op.neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
        n_out.y    = r_st[C_Q_W].op.neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.side.valid <= 1'b0;
        end else if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_ofs = r_out;

endmodule
`default_nettype wire

### hdl/cec_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cec_sqrt
// radius: squares of the offsets, their sum, then a digit by digit
// floor square root, one result bit per stage
// ----------------------------------------------------------------------------
module cec_sqrt (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire cec_pkg::t_ofs i_ofs,
    output cec_pkg::t_res o_res
);
    import cec_pkg::*;

    typedef struct packed {
        t_ofs                ofs;
        logic [C_SQ_W-1:0]   s;
        logic [C_SREM_W-1:0] rem;
        logic [C_OFS_W-1:0]  root;
    } t_sst;

    t_ofs               r_a_ofs;
    logic [C_SQ_W-1:0]  r_a_sqx, r_a_sqy;
    t_sst               r_st [0:C_OFS_W];
    logic [C_OFS_W-1:0] mag_x, mag_y;
    t_sst               n_st0;

    always_comb begin
        mag_x = i_ofs.x[C_OFS_W] ? C_OFS_W'(-i_ofs.x) : C_OFS_W'(i_ofs.x);
        mag_y = i_ofs.y[C_OFS_W] ? C_OFS_W'(-i_ofs.y) : C_OFS_W'(i_ofs.y);
        n_st0     = '0;
        n_st0.ofs = r_a_ofs;
        n_st0.s   = r_a_sqx + r_a_sqy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ofs.side.valid        <= 1'b0;
            r_st[0].ofs.side.valid    <= 1'b0;
        end else if (i_en) begin
            r_a_ofs.side.valid        <= i_ofs.side.valid;
            r_st[0].ofs.side.valid    <= r_a_ofs.side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ofs.side.event_ok <= i_ofs.side.event_ok;
            r_a_ofs.side.bx       <= i_ofs.side.bx;
            r_a_ofs.side.by       <= i_ofs.side.by;
            r_a_ofs.x             <= i_ofs.x;
            r_a_ofs.y             <= i_ofs.y;
            r_a_sqx               <= mag_x * mag_x;
            r_a_sqy               <= mag_y * mag_y;
            r_st[0].ofs.side.event_ok <= n_st0.ofs.side.event_ok;
            r_st[0].ofs.side.bx   <= n_st0.ofs.side.bx;
            r_st[0].ofs.side.by   <= n_st0.ofs.side.by;
            r_st[0].ofs.x         <= n_st0.ofs.x;
            r_st[0].ofs.y         <= n_st0.ofs.y;
            r_st[0].s             <= n_st0.s;
            r_st[0].rem           <= n_st0.rem;
            r_st[0].root          <= n_st0.root;
        end
    end

    for (genvar k = 1; k <= C_OFS_W; k++) begin : g_digit
        localparam int P = C_OFS_W - k;
        t_sst                n_st;
        logic [C_SREM_W-1:0] t;
        logic [C_SREM_W-1:0] trial;

        always_comb begin
            n_st  = r_st[k-1];
            t     = {r_st[k-1].rem[C_SREM_W-3:0], r_st[k-1].s[2*P+1 -: 2]};
            trial = {2'b00, r_st[k-1].root, 2'b01};
            if (t >= trial) begin
                n_st.rem  = t - trial;
                n_st.root = {r_st[k-1].root[C_OFS_W-2:0], 1'b1};
            end else begin
                n_st.rem  = t;
                n_st.root = {r_st[k-1].root[C_OFS_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k].ofs.side.valid <= 1'b0;
            end else if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_res.side = r_st[C_OFS_W].ofs.side;
    assign o_res.x    = r_st[C_OFS_W].ofs.x;
    assign o_res.y    = r_st[C_OFS_W].ofs.y;
    assign o_res.root = r_st[C_OFS_W].root;

endmodule
`default_nettype wire

### tb/circle_event_circumcircle_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_event_circumcircle_core_checker
// watches the word channels and the margin register, predicts every result
// word of the circumcircle core and compares it field by field
// ----------------------------------------------------------------------------
module circle_event_circumcircle_core_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [cec_pkg::C_MARGIN_W-1:0]       i_cfg_wdata,
    input  wire logic                                 i_in_valid,
    input  wire logic                                 i_in_stall,
    input  wire logic                                 i_neighbours_ok,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_left_x,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_left_y,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_centre_x,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_centre_y,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_right_x,
    input  wire logic signed [cec_pkg::C_COORD_W-1:0] i_right_y,
    input  wire logic                                 i_out_valid,
    input  wire logic                                 i_out_stall,
    input  wire logic                                 i_event_valid,
    input  wire logic signed [cec_pkg::C_OUT_W-1:0]   i_vertex_x,
    input  wire logic signed [cec_pkg::C_OUT_W-1:0]   i_vertex_y,
    input  wire logic signed [cec_pkg::C_OUT_W-1:0]   i_event_y,
    input  wire logic                                 i_overflow,
    output int                                        o_fail_count,
    output int                                        o_pending,
    output int                                        o_event_count,
    output int                                        o_ovf_count
);
    import cec_pkg::*;

    localparam longint C_LIMIT = 64'h8100_0000;
    localparam longint C_HI    = (64'sd1 <<< (C_OUT_W - 1)) - 1;
    localparam longint C_LO    = -(64'sd1 <<< (C_OUT_W - 1));

    typedef struct {
        logic                      event_valid;
        logic signed [C_OUT_W-1:0] vertex_x;
        logic signed [C_OUT_W-1:0] vertex_y;
        logic signed [C_OUT_W-1:0] event_y;
        logic                      overflow;
    } t_circle;

    t_circle               circle_q[$];
    logic [C_MARGIN_W-1:0] margin;

    function automatic longint div_round(longint num, longint den);
        longint unsigned un;
        longint unsigned ud;
        longint unsigned q;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q  = (2 * un + ud) / (2 * ud);
        if (q > C_LIMIT) q = C_LIMIT;
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [C_OUT_W-1:0] clamp_out(longint v, ref logic ovf);
        if (v > C_HI) begin
            v = C_HI; ovf = 1'b1;
        end
        if (v < C_LO) begin
            v = C_LO; ovf = 1'b1;
        end
        return v[C_OUT_W-1:0];
    endfunction

    function automatic t_circle predict_circle(logic ok, longint lx, longint ly, longint bx,
                                               longint by, longint rx, longint ry);
        t_circle res;
        longint  ax, ay, cx, cy, det, ha, hc, ox, oy;
        longint unsigned mx, my, rad;
        logic    ovf;
        res = '{1'b0, '0, '0, '0, 1'b0};
        ax  = lx - bx; ay = ly - by;
        cx  = rx - bx; cy = ry - by;
        det = 2 * (ax * cy - ay * cx);
        if (!ok || det >= -longint'(margin)) return res;
        ha  = ax * ax + ay * ay;
        hc  = cx * cx + cy * cy;
        ox  = div_round(cy * ha - ay * hc, det);
        oy  = div_round(ax * hc - cx * ha, det);
        mx  = (ox < 0) ? -ox : ox;
        my  = (oy < 0) ? -oy : oy;
        rad = int_sqrt(mx * mx + my * my);
        ovf = 1'b0;
        res.event_valid = 1'b1;
        res.vertex_x    = clamp_out(ox + bx, ovf);
        res.vertex_y    = clamp_out(oy + by, ovf);
        res.event_y     = clamp_out(oy + by + longint'(rad), ovf);
        res.overflow    = ovf;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_circle want;
        if (!i_rst_n) begin
            margin <= '0;
        end else begin
            if (i_cfg_we) margin <= i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                circle_q.push_back(predict_circle(i_neighbours_ok, i_left_x, i_left_y,
                                                  i_centre_x, i_centre_y, i_right_x,
                                                  i_right_y));
            end
            if (i_out_valid && !i_out_stall) begin
                if (circle_q.size() == 0) begin
                    $display("%0t: result word with no expectation", $realtime);
                    o_fail_count++;
                end else begin
                    want = circle_q.pop_front();
                    if (i_event_valid) o_event_count++;
                    if (i_overflow) o_ovf_count++;
                    if (i_event_valid !== want.event_valid)
                        report_mismatch("event_valid", i_event_valid, want.event_valid);
                    if (i_vertex_x !== want.vertex_x)
                        report_mismatch("vertex_x", i_vertex_x, want.vertex_x);
                    if (i_vertex_y !== want.vertex_y)
                        report_mismatch("vertex_y", i_vertex_y, want.vertex_y);
                    if (i_event_y !== want.event_y)
                        report_mismatch("event_y", i_event_y, want.event_y);
                    if (i_overflow !== want.overflow)
                        report_mismatch("overflow", i_overflow, want.overflow);
                end
            end
        end
        o_pending = circle_q.size();
    end

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_event_count = 0;
        o_ovf_count   = 0;
    end

endmodule

### tb/circle_event_circumcircle_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_event_circumcircle_core_test
// drives site triplets into the circumcircle core under random idling on
// both channels, steps the det margin through its range, and lets the
// checker judge every result word
// ----------------------------------------------------------------------------
module circle_event_circumcircle_core_test;
    import cec_pkg::*;

    localparam int C_LATENCY = 75;
    localparam int C_RANDOM  = 450;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [C_MARGIN_W-1:0]       cfg_wdata;
    logic                        in_valid;
    logic                        in_stall;
    logic                        nb_ok;
    logic signed [C_COORD_W-1:0] lx, ly, bx, by, rx, ry;
    logic                        out_valid;
    logic                        out_stall;
    logic                        event_valid;
    logic signed [C_OUT_W-1:0]   vertex_x, vertex_y, event_y;
    logic                        overflow;
    int                          fail_count, pending, event_count, ovf_count;
    int                          sent;
    bit                          quiet;     // no idling in the closing stretch

    circle_event_circumcircle_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_valid         (in_valid),
        .o_stall         (in_stall),
        .i_neighbours_ok (nb_ok),
        .i_left_x        (lx),
        .i_left_y        (ly),
        .i_centre_x      (bx),
        .i_centre_y      (by),
        .i_right_x       (rx),
        .i_right_y       (ry),
        .o_valid         (out_valid),
        .i_stall         (out_stall),
        .o_event_valid   (event_valid),
        .o_vertex_x      (vertex_x),
        .o_vertex_y      (vertex_y),
        .o_event_y       (event_y),
        .o_overflow      (overflow)
    );

    circle_event_circumcircle_core_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_neighbours_ok (nb_ok),
        .i_left_x        (lx),
        .i_left_y        (ly),
        .i_centre_x      (bx),
        .i_centre_y      (by),
        .i_right_x       (rx),
        .i_right_y       (ry),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_event_valid   (event_valid),
        .i_vertex_x      (vertex_x),
        .i_vertex_y      (vertex_y),
        .i_event_y       (event_y),
        .i_overflow      (overflow),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_event_count   (event_count),
        .o_ovf_count     (ovf_count)
    );

    // 12 ns clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // safety net against a hung handshake
    initial begin
        #20ms;
        $display("timeout with %0d words outstanding", pending);
        $display("Verification failed");
        $finish;
    end

    // receiver stall: bursts of random length, with calm stretches between
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(10, 40)) @(negedge clk);
            end
        end
    end

    // one word onto the input channel; returns on the falling edge after acceptance
    task automatic send_word(bit ok, int ax0, int ay0, int bx0, int by0, int cx0, int cy0);
        if (!quiet && $urandom_range(0, 6) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid <= 1'b1;
        nb_ok    <= ok;
        lx <= ax0[15:0]; ly <= ay0[15:0];
        bx <= bx0[15:0]; by <= by0[15:0];
        rx <= cx0[15:0]; ry <= cy0[15:0];
        forever begin
            #1;
            if (!in_stall) break;
            @(negedge clk);
        end
        @(negedge clk);
        sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (C_LATENCY + 5) @(negedge clk);
    endtask

    // margin writes only with the pipeline empty
    task automatic set_margin(logic [C_MARGIN_W-1:0] m);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic int any_coord();
        return $signed(16'($urandom));
    endfunction

    // mostly clustered triplets with a counter-clockwise bias, some raw noise
    task automatic random_word();
        int ox, oy, sp, a0, a1, b0, b1, c0, c1, t;
        longint cr;
        if ($urandom_range(0, 4) == 0) begin
            send_word($urandom_range(0, 7) != 0, any_coord(), any_coord(), any_coord(),
                      any_coord(), any_coord(), any_coord());
            return;
        end
        sp = 1 << $urandom_range(2, 14);
        ox = $urandom_range(0, 65535) - 32768;
        oy = $urandom_range(0, 65535) - 32768;
        a0 = ox + $urandom_range(0, 2 * sp) - sp; a1 = oy + $urandom_range(0, 2 * sp) - sp;
        b0 = ox + $urandom_range(0, 2 * sp) - sp; b1 = oy + $urandom_range(0, 2 * sp) - sp;
        c0 = ox + $urandom_range(0, 2 * sp) - sp; c1 = oy + $urandom_range(0, 2 * sp) - sp;
        a0 = (a0 > 32767) ? 32767 : (a0 < -32768) ? -32768 : a0;
        a1 = (a1 > 32767) ? 32767 : (a1 < -32768) ? -32768 : a1;
        b0 = (b0 > 32767) ? 32767 : (b0 < -32768) ? -32768 : b0;
        b1 = (b1 > 32767) ? 32767 : (b1 < -32768) ? -32768 : b1;
        c0 = (c0 > 32767) ? 32767 : (c0 < -32768) ? -32768 : c0;
        c1 = (c1 > 32767) ? 32767 : (c1 < -32768) ? -32768 : c1;
        // swap ends so most triplets turn counter-clockwise
        cr = longint'(a0 - b0) * (c1 - b1) - longint'(a1 - b1) * (c0 - b0);
        if (cr > 0 && $urandom_range(0, 3) != 0) begin
            t = a0; a0 = c0; c0 = t;
            t = a1; a1 = c1; c1 = t;
        end
        send_word($urandom_range(0, 15) != 0, a0, a1, b0, b1, c0, c1);
    endtask

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        nb_ok     = 1'b0;
        {lx, ly, bx, by, rx, ry} = '0;
        sent      = 0;
        quiet     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words at reset margin 0
        send_word(1, -16, 0, 0, 0, 16, -16);            // clockwise
        send_word(0, -16, 0, 0, 0, 16, -16);            // no neighbours
        send_word(1, 16, -16, 0, 0, -16, 0);            // plain event
        send_word(1, -10, -10, 0, 0, 10, 10);           // collinear, zero determinant
        send_word(1, 5, 5, 5, 5, 5, 5);                 // coincident sites
        send_word(1, 1, 0, 0, 0, 0, -1);                // smallest event, d of -2
        send_word(1, -32768, 0, 0, 0, 32767, 1);        // huge circle, saturation
        send_word(1, -32768, 32767, 0, 0, 32767, -32766); // offset clamp
        send_word(1, -32768, -32768, 32767, 32767, -32768, 32767);
        send_word(1, 32767, -32768, -32768, -32768, 32767, 32767);
        send_word(1, -32768, -32768, 32767, -32768, -32768, 32767);
        send_word(1, -1, -1, -1, -1, -1, -1);

        // margin at its top: determinant of -256 passes, -254 does not
        set_margin(8'd255);
        send_word(1, 128, 0, 0, 0, 0, -1);
        send_word(1, 127, 0, 0, 0, 0, -1);
        send_word(1, -32768, 0, 0, 0, 32767, 1);
        set_margin(8'd1);
        send_word(1, 1, 0, 0, 0, 0, -1);
        set_margin(8'd2);
        send_word(1, 1, 0, 0, 0, 0, -1);                // d equals minus margin: no event
        send_word(1, 2, 0, 0, 0, 0, -1);

        // random phases across margin settings
        set_margin(8'd0);
        repeat (C_RANDOM / 4) random_word();
        drain();                                        // full pause mid run
        repeat (C_RANDOM / 4) random_word();
        set_margin(8'($urandom_range(3, 254)));
        repeat (C_RANDOM / 4) random_word();
        set_margin(8'd255);
        repeat (C_RANDOM / 8) random_word();
        set_margin(8'd0);
        quiet = 1'b1;                                   // back-to-back closing stretch
        repeat (C_RANDOM / 8) random_word();
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (C_LATENCY + 10) @(posedge clk);
        $display("%0d triplets sent, %0d circle events and %0d saturated results seen",
                 sent, event_count, ovf_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
hdl/cec_pkg.sv
hdl/cec_front.sv
hdl/cec_div.sv
hdl/cec_sqrt.sv
hdl/circle_event_circumcircle_core.sv
tb/circle_event_circumcircle_core_checker.sv
tb/circle_event_circumcircle_core_test.sv
